[sv/kwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, types and codes for the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int NUM_LISTS  = 8;
    localparam int LIST_DEPTH = 64;
    localparam int VALUE_BITS = 32;

    localparam int LIST_BITS  = $clog2(NUM_LISTS);
    localparam int LANES      = 1 << LIST_BITS;
    localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int MEM_DEPTH  = NUM_LISTS * LIST_DEPTH;
    localparam int MEM_ABITS  = $clog2(MEM_DEPTH);
    localparam int TOTAL_BITS = $clog2(MEM_DEPTH + 1);
    localparam int LVL_BITS   = (LIST_BITS > 1) ? $clog2(LIST_BITS) : 1;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_POP,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [LIST_BITS-1:0]   list;
        logic [VALUE_BITS-1:0]  data;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EMIT,
        ST_FILL
    } t_state;

    // sign-extend or cut a 32-bit beat value to the stored width
    function automatic logic [VALUE_BITS-1:0] to_stored(input logic [31:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[VALUE_BITS-1:0];
    endfunction

    // sign-extend a stored value, then cut to the 32-bit result field
    function automatic logic [31:0] to_result(input logic [VALUE_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(signed'(v));
        return w[31:0];
    endfunction

endpackage

[sv/k_way_sorted_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges several sorted lists into one ascending stream of pop results.
//
//   channel  direction  handshake          fields
//   in       input      i_valid / o_stall  i_kind, i_list_index, i_value
//   out      output     o_valid / i_stall  o_out_value, o_source_list,
//                                          o_empty_res, o_last, o_overflow
//
// A load or clear is done while the engine is idle. A pop runs a start step,
// the halving min-reduction over the list heads, and an emit step; a fill step
// follows when the popped list needs its next head from the element memory.
// Reset empties every list and clears the overflow flag; memory is not swept.
// A two-entry queue lets the input side keep taking beats while a result
// waits on i_stall.
// ----------------------------------------------------------------------------
module k_way_sorted_merge
    import kwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_list_index,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_value,
    output logic [2:0]  o_source_list,
    output logic        o_empty_res,
    output logic        o_last,
    output logic        o_overflow
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    kwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_list_index (i_list_index),
        .i_value      (i_value),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_full       (q_full)
    );

    kwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    kwm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_value   (o_out_value),
        .o_source_list (o_source_list),
        .o_empty_res   (o_empty_res),
        .o_last        (o_last),
        .o_overflow    (o_overflow)
    );

endmodule

[sv/kwm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_front
// Input stage: takes beats, drops ignored kinds and loads to missing lists,
// and hands decoded commands to the queue.
// ----------------------------------------------------------------------------
module kwm_front
    import kwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_list_index,
    input  logic [31:0] i_value,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_full
);

    logic r_valid;
    t_cmd r_cmd;
    logic keep;
    t_cmd cmd;
    logic accept;

    always_comb begin
        keep      = 1'b0;
        cmd.op    = OP_LOAD;
        cmd.list  = LIST_BITS'(i_list_index);
        cmd.data  = to_stored(i_value);
        case (i_kind)
            KIND_LOAD: begin
                keep   = int'(i_list_index) < NUM_LISTS;
                cmd.op = OP_LOAD;
            end
            KIND_POP: begin
                keep   = 1'b1;
                cmd.op = OP_POP;
            end
            KIND_CLEAR: begin
                keep   = 1'b1;
                cmd.op = OP_CLEAR;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;
    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cmd;
        end
    end

endmodule

[sv/kwm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_queue
// Two-entry command queue between the input stage and the merge engine.
// ----------------------------------------------------------------------------
module kwm_queue
    import kwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_cmd   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

[sv/kwm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_back
// Merge engine: element memory, per-list head registers and counters, a
// halving min-reduction over the heads, and the result register.
// ----------------------------------------------------------------------------
module kwm_back
    import kwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_value,
    output logic [2:0]  o_source_list,
    output logic        o_empty_res,
    output logic        o_last,
    output logic        o_overflow
);

    typedef struct packed {
        logic                  vld;
        logic [VALUE_BITS-1:0] val;
        logic [LIST_BITS-1:0]  idx;
    } t_cand;

    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.vld && (!a.vld || ($signed(b.val) < $signed(a.val)))) begin
            return b;
        end
        return a;
    endfunction

    logic [VALUE_BITS-1:0] mem [MEM_DEPTH];
    logic [VALUE_BITS-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_fill [NUM_LISTS];
    logic [COUNT_BITS-1:0] r_rp   [NUM_LISTS];
    logic [VALUE_BITS-1:0] r_head [NUM_LISTS];
    t_cand                 r_cand [LANES];
    logic [LVL_BITS-1:0]   r_level;
    logic [TOTAL_BITS-1:0] r_total;
    logic                  r_ovf;

    logic                  r_ovalid;
    logic [31:0]           r_out_value;
    logic [2:0]            r_source_list;
    logic                  r_empty_res;
    logic                  r_last;
    logic                  r_overflow;

    logic                  do_load, do_clear, do_start, do_step, do_emit, do_fill;
    logic                  out_free;
    logic                  load_full;
    logic                  refill;
    t_cand                 best;
    logic [COUNT_BITS-1:0] rp_next;
    logic [MEM_ABITS-1:0]  wr_addr;
    logic [MEM_ABITS-1:0]  rd_addr;
    logic [7:0]            src_wide;

    assign best      = r_cand[0];
    assign out_free  = !r_ovalid || !i_stall;
    assign load_full = r_fill[i_q_cmd.list] == COUNT_BITS'(LIST_DEPTH);
    assign rp_next   = r_rp[best.idx] + COUNT_BITS'(1);
    assign refill    = best.vld && (rp_next < r_fill[best.idx]);
    assign wr_addr   = MEM_ABITS'(i_q_cmd.list) * MEM_ABITS'(LIST_DEPTH)
                     + MEM_ABITS'(r_fill[i_q_cmd.list]);
    assign rd_addr   = MEM_ABITS'(best.idx) * MEM_ABITS'(LIST_DEPTH)
                     + MEM_ABITS'(rp_next);
    assign src_wide  = 8'(best.idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        do_load  = 1'b0;
        do_clear = 1'b0;
        do_start = 1'b0;
        do_step  = 1'b0;
        do_emit  = 1'b0;
        do_fill  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_cmd.op)
                        OP_LOAD:  do_load = 1'b1;
                        OP_CLEAR: do_clear = 1'b1;
                        OP_POP: begin
                            do_start = 1'b1;
                            n_state  = ST_REDUCE;
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            ST_REDUCE: begin
                do_step = 1'b1;
                if (r_level == LVL_BITS'(LIST_BITS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    do_emit = 1'b1;
                    n_state = refill ? ST_FILL : ST_IDLE;
                end
            end
            ST_FILL: begin
                do_fill = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // list counters, totals and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_fill[j] <= '0;
                r_rp[j]   <= '0;
            end
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (do_load) begin
            if (load_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_fill[i_q_cmd.list] <= r_fill[i_q_cmd.list] + COUNT_BITS'(1);
                r_total              <= r_total + TOTAL_BITS'(1);
            end
        end else if (do_clear) begin
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_fill[j] <= '0;
                r_rp[j]   <= '0;
            end
            r_total <= '0;
        end else if (do_emit && best.vld) begin
            r_rp[best.idx] <= rp_next;
            r_total        <= r_total - TOTAL_BITS'(1);
        end
    end

    // heads, reduction lanes and level counter
    always_ff @(posedge i_clk) begin
        if (do_load && !load_full && (r_rp[i_q_cmd.list] == r_fill[i_q_cmd.list])) begin
            r_head[i_q_cmd.list] <= i_q_cmd.data;
        end
        if (do_fill) begin
            r_head[best.idx] <= r_rdata;
        end
        if (do_start) begin
            for (int j = 0; j < NUM_LISTS; j++) begin
                r_cand[j].vld <= r_rp[j] < r_fill[j];
                r_cand[j].val <= r_head[j];
                r_cand[j].idx <= LIST_BITS'(j);
            end
            for (int j = NUM_LISTS; j < LANES; j++) begin
                r_cand[j].vld <= 1'b0;
                r_cand[j].val <= '0;
                r_cand[j].idx <= LIST_BITS'(j);
            end
            r_level <= '0;
        end else if (do_step) begin
            for (int j = 0; j < LANES / 2; j++) begin
                r_cand[j] <= pick(r_cand[2 * j], r_cand[2 * j + 1]);
            end
            r_level <= r_level + LVL_BITS'(1);
        end
    end

    // element memory
    always_ff @(posedge i_clk) begin
        if (do_load && !load_full) begin
            mem[wr_addr] <= i_q_cmd.data;
        end
        r_rdata <= mem[rd_addr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (do_emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_out_value   <= best.vld ? to_result(best.val) : 32'd0;
            r_source_list <= best.vld ? src_wide[2:0] : 3'd0;
            r_empty_res   <= !best.vld;
            r_last        <= best.vld && (r_total == TOTAL_BITS'(1));
            r_overflow    <= r_ovf;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_value   = r_out_value;
    assign o_source_list = r_source_list;
    assign o_empty_res   = r_empty_res;
    assign o_last        = r_last;
    assign o_overflow    = r_overflow;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for k_way_sorted_merge. A behavioral model of the list
// store predicts every pop beat: the smallest head with ties to the lowest
// list, the last and empty flags, and the sticky overflow flag. Directed
// beats cover the value extremes, ties, empty pops, clears and the unused
// kind. Random rounds load mostly sorted runs and merge them back out. Both
// channels idle and stall at random; one phase holds the output off long
// enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
    import kwm_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 16;

    typedef logic signed [VALUE_BITS-1:0] t_elem;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  src;
        logic        empty;
        logic        last;
        logic        ovf;
    } t_pop_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_kind;
    logic [2:0]  i_list_index;
    logic [31:0] i_value;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_out_value;
    logic [2:0]  o_source_list;
    logic        o_empty_res;
    logic        o_last;
    logic        o_overflow;

    // merge state as the block should hold it
    t_elem       list_mem [NUM_LISTS][LIST_DEPTH];
    int unsigned loaded [NUM_LISTS];
    int unsigned popped [NUM_LISTS];
    bit          dropped_load;

    t_pop_result pending_pops [$];
    int          errors;
    int          beats_sent;
    int          cycle_count;
    int          in_gap_max  = 12;
    int          out_gap_max = 12;
    int          hold_cycles = 0;

    k_way_sorted_merge u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_list_index  (i_list_index),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_value   (o_out_value),
        .o_source_list (o_source_list),
        .o_empty_res   (o_empty_res),
        .o_last        (o_last),
        .o_overflow    (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned elems_left();
        int unsigned n;
        n = 0;
        for (int l = 0; l < NUM_LISTS; l++) begin
            n += loaded[l] - popped[l];
        end
        return n;
    endfunction

    // apply one accepted beat to the merge state, queue the pop result
    function automatic void track_merge(input logic [1:0] kind, input logic [2:0] idx,
                                        input logic [31:0] val);
        t_pop_result res;
        t_elem       best_val;
        int          best;
        bit          found;
        case (kind)
            KIND_LOAD: begin
                if (idx < NUM_LISTS) begin
                    if (loaded[idx] >= LIST_DEPTH) begin
                        dropped_load = 1'b1;
                    end else begin
                        list_mem[idx][loaded[idx]] = VALUE_BITS'(signed'(val));
                        loaded[idx]++;
                    end
                end
            end
            KIND_CLEAR: begin
                for (int l = 0; l < NUM_LISTS; l++) begin
                    loaded[l] = 0;
                    popped[l] = 0;
                end
            end
            KIND_POP: begin
                found    = 1'b0;
                best     = 0;
                best_val = '0;
                for (int l = 0; l < NUM_LISTS; l++) begin
                    if (popped[l] < loaded[l]) begin
                        if (!found || list_mem[l][popped[l]] < best_val) begin
                            found    = 1'b1;
                            best     = l;
                            best_val = list_mem[l][popped[l]];
                        end
                    end
                end
                res     = '0;
                res.ovf = dropped_load;
                if (!found) begin
                    res.empty = 1'b1;
                end else begin
                    res.value = 32'(best_val);
                    res.src   = 3'(best);
                    res.last  = (elems_left() == 1);
                    popped[best]++;
                end
                pending_pops.push_back(res);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [2:0] idx,
                             input logic [31:0] val);
        int gap;
        gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_list_index <= idx;
        i_value      <= val;
        do @(posedge i_clk); while (o_stall);
        track_merge(kind, idx, val);
        if (kind != KIND_NONE) beats_sent++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_pops.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic pop_all(input int extra);
        int n;
        n = int'(elems_left()) + extra;
        repeat (n) send_beat(KIND_POP, 3'($urandom), $urandom);
    endtask

    function automatic longint start_point();
        case ($urandom_range(0, 4))
            0:       return -64'sd2147483648 + longint'($urandom_range(0, 3));
            1:       return 64'sd2147483647 - longint'($urandom_range(0, 20000));
            2:       return longint'($urandom_range(0, 40)) - 20;
            default: return longint'(signed'($urandom()));
        endcase
    endfunction

    function automatic longint next_up(input longint tail);
        int     step;
        longint nxt;
        step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5000);
        nxt  = tail + step;
        if (nxt > 64'sd2147483647) nxt = 64'sd2147483647;
        return nxt;
    endfunction

    task automatic merge_round();
        longint               tail [NUM_LISTS];
        logic [NUM_LISTS-1:0] mask;
        int                   n_loads;
        int                   l;
        bit                   fresh;
        fresh = 1'($urandom_range(0, 1));
        for (int k = 0; k < NUM_LISTS; k++) begin
            if (loaded[k] > LIST_DEPTH - 32) fresh = 1'b1;
            tail[k] = start_point();
        end
        if (fresh) send_beat(KIND_CLEAR, 3'($urandom), $urandom);
        mask    = NUM_LISTS'($urandom_range(1, (1 << NUM_LISTS) - 1));
        n_loads = $urandom_range(1, 30);
        repeat (n_loads) begin
            case ($urandom_range(0, 39))
                0, 1: send_beat(KIND_NONE, 3'($urandom), $urandom);
                2, 3, 4, 5, 6, 7: send_beat(KIND_POP, 3'($urandom), $urandom);
                8, 9: send_beat(KIND_LOAD, 3'($urandom), $urandom);
                10: send_beat(KIND_CLEAR, 3'($urandom), $urandom);
                default: begin
                    do l = $urandom_range(0, NUM_LISTS - 1); while (!mask[l]);
                    tail[l] = next_up(tail[l]);
                    send_beat(KIND_LOAD, 3'(l), 32'(tail[l]));
                end
            endcase
        end
        pop_all(($urandom_range(0, 5) == 0) ? -int'($urandom_range(1, 10))
                                            : int'($urandom_range(0, 2)));
    endtask

    task automatic test_directed();
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_NONE,  3'd7, 32'hFFFF_FFFF);
        send_beat(KIND_LOAD,  3'd0, 32'h7FFF_FFFF);
        send_beat(KIND_LOAD,  3'd7, 32'h8000_0000);
        send_beat(KIND_LOAD,  3'd3, 32'h0);
        send_beat(KIND_LOAD,  3'd5, 32'h0);
        send_beat(KIND_LOAD,  3'd1, 32'hFFFF_FFFF);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_LOAD,  3'd2, 32'h7FFF_FFFF);
        send_beat(KIND_POP,   3'd7, 32'hFFFF_FFFF);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
        // popped slots stay used, new loads go behind them
        send_beat(KIND_LOAD,  3'd4, 32'd5);
        send_beat(KIND_LOAD,  3'd4, 32'd6);
        send_beat(KIND_LOAD,  3'd6, 32'hFFFF_FFFD);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_CLEAR, 3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
        send_beat(KIND_LOAD,  3'd6, 32'd1);
        send_beat(KIND_NONE,  3'd0, 32'h0);
        send_beat(KIND_POP,   3'd0, 32'h0);
    endtask

    task automatic test_random_merge(input int quota);
        int target;
        target = beats_sent + quota;
        while (beats_sent < target) begin
            case ($urandom_range(0, 3))
                0: begin in_gap_max = 0;  out_gap_max = 0;  end
                1: begin in_gap_max = 12; out_gap_max = 0;  end
                2: begin in_gap_max = 0;  out_gap_max = 12; end
                default: begin in_gap_max = 12; out_gap_max = 12; end
            endcase
            merge_round();
        end
    endtask

    task automatic test_backpressure();
        in_gap_max = 0;
        out_gap_max = 3;
        send_beat(KIND_CLEAR, 3'd0, 32'h0);
        repeat (16) send_beat(KIND_LOAD, 3'($urandom), $urandom);
        hold_cycles = 200;
        repeat (24) send_beat(KIND_POP, 3'($urandom), $urandom);
        wait_drain();
    endtask

    task automatic test_overflow();
        longint tail;
        int     full_list;
        int     other;
        in_gap_max  = 4;
        out_gap_max = 4;
        full_list = $urandom_range(0, NUM_LISTS - 1);
        other     = (full_list + 1 + $urandom_range(0, NUM_LISTS - 2)) % NUM_LISTS;
        send_beat(KIND_CLEAR, 3'd0, 32'h0);
        tail = start_point();
        repeat (LIST_DEPTH + 3) begin
            tail = next_up(tail);
            send_beat(KIND_LOAD, 3'(full_list), 32'(tail));
        end
        repeat (5) send_beat(KIND_LOAD, 3'(other), $urandom);
        pop_all(1);
        // still full after draining, only a clear frees the slots
        send_beat(KIND_LOAD, 3'(full_list), $urandom);
        send_beat(KIND_POP, 3'd0, 32'h0);
        send_beat(KIND_CLEAR, 3'd0, 32'h0);
        send_beat(KIND_POP, 3'd0, 32'h0);
    endtask

    task automatic test_drain_pause();
        in_gap_max  = 12;
        out_gap_max = 12;
        send_beat(KIND_CLEAR, 3'd0, 32'h0);
        repeat (10) send_beat(KIND_LOAD, 3'($urandom), $urandom);
        repeat (5) send_beat(KIND_POP, 3'($urandom), $urandom);
        wait_drain();
        pop_all(1);
    endtask

    // output side: random stall per beat, plus an optional long hold
    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            n = (out_gap_max == 0) ? 0 : $urandom_range(0, out_gap_max);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pop_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pops.size() == 0) begin
                $display("%0t: unexpected result, expected none actual value %h list %0d",
                         $time, o_out_value, o_source_list);
                errors++;
            end else begin
                want = pending_pops.pop_front();
                compare_field("out_value", want.value, o_out_value);
                compare_field("source_list", 32'(want.src), 32'(o_source_list));
                compare_field("empty_res", 32'(want.empty), 32'(o_empty_res));
                compare_field("last", 32'(want.last), 32'(o_last));
                compare_field("overflow", 32'(want.ovf), 32'(o_overflow));
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_kind       <= KIND_LOAD;
        i_list_index <= '0;
        i_value      <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_merge(350);
        test_backpressure();
        test_overflow();
        test_random_merge(350);
        test_drain_pause();
        wait_drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
sv/kwm_pkg.sv
sv/kwm_front.sv
sv/kwm_queue.sv
sv/kwm_back.sv
sv/k_way_sorted_merge.sv
tb/sv/tb.sv
